>>> hw/rtl/ctg_pkg.sv
package ctg_pkg;

  // rounding divide by ten thousand, done as reciprocal multiply plus one correction
  localparam int REL_SCALE        = 10000;
  localparam int REL_HALF         = 5000;
  localparam int RECIP_SPAN       = 429496;   // floor(2**32 / 10000)
  localparam int RECIP_SPAN_W     = 19;
  localparam int RECIP_SPAN_SHIFT = 32;
  localparam int RECIP_FRAC       = 26843;    // floor(2**28 / 10000)
  localparam int RECIP_FRAC_W     = 15;
  localparam int RECIP_FRAC_SHIFT = 28;
  localparam int REM_W            = 15;
  localparam int FRAC_W           = 28;
  localparam int QB_W             = 15;
  localparam int REL_W            = 14;
  localparam int DIM_W            = 24;

  localparam int ADDR_W           = 5;
  localparam int DATA_W           = 32;
  localparam int OUT_TDATA_W      = 200;

  localparam logic [2:0] REG_CAPTION_TYPE       = 3'd0;
  localparam logic [2:0] REG_ESCAPE_MODE        = 3'd1;
  localparam logic [2:0] REG_GAP                = 3'd2;
  localparam logic [2:0] REG_ESCAPE_IS_RELATIVE = 3'd3;
  localparam logic [2:0] REG_ESCAPE_RELATIVE    = 3'd4;
  localparam logic [2:0] REG_ESCAPE_ABSOLUTE    = 3'd5;
  localparam logic [2:0] REG_LINE_LENGTH        = 3'd6;
  localparam logic [2:0] REG_FIT_LINE_LENGTH    = 3'd7;

  localparam logic [1:0] CAP_SNAP     = 2'd0;
  localparam logic [1:0] CAP_STRAIGHT = 2'd1;
  localparam logic [1:0] CAP_KNEE3    = 2'd2;
  localparam logic [1:0] CAP_KNEE4    = 2'd3;

  localparam logic [1:0] ESC_HORIZ    = 2'd0;
  localparam logic [1:0] ESC_VERT     = 2'd1;
  localparam logic [1:0] ESC_BEST     = 2'd2;

  localparam logic [1:0] SIDE_LEFT    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT   = 2'd1;
  localparam logic [1:0] SIDE_TOP     = 2'd2;
  localparam logic [1:0] SIDE_BOTTOM  = 2'd3;

  localparam logic [1:0] PTS_TWO      = 2'd2;
  localparam logic [1:0] PTS_THREE    = 2'd3;

  typedef struct packed {
    logic [1:0]        caption_type;
    logic [1:0]        escape_mode;
    logic [DIM_W-1:0]  gap;
    logic              escape_is_relative;
    logic [REL_W-1:0]  escape_relative;
    logic [DIM_W-1:0]  escape_absolute;
    logic [DIM_W-1:0]  line_length;
    logic              fit_line_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  escape_side;
    logic [31:0] p2_y;
    logic [31:0] p2_x;
    logic [31:0] p1_y;
    logic [31:0] p1_x;
    logic [31:0] p0_y;
    logic [31:0] p0_x;
    logic [1:0]  point_count;
  } result_t;

endpackage

>>> hw/rtl/ctg_cfg_regs.sv
module ctg_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctg_pkg::ADDR_W-1:0] paddr,
  input  logic [ctg_pkg::DATA_W-1:0] pwdata,
  output logic [ctg_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ctg_pkg::cfg_t              cfg
);
  import ctg_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.caption_type       <= CAP_KNEE3;
      cfg.escape_mode        <= ESC_HORIZ;
      cfg.gap                <= '0;
      cfg.escape_is_relative <= 1'b1;
      cfg.escape_relative    <= REL_W'(REL_HALF);
      cfg.escape_absolute    <= '0;
      cfg.line_length        <= '0;
      cfg.fit_line_length    <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_CAPTION_TYPE:       cfg.caption_type       <= pwdata[1:0];
        REG_ESCAPE_MODE:        cfg.escape_mode        <= pwdata[1:0];
        REG_GAP:                cfg.gap                <= pwdata[DIM_W-1:0];
        REG_ESCAPE_IS_RELATIVE: cfg.escape_is_relative <= pwdata[0];
        REG_ESCAPE_RELATIVE:    cfg.escape_relative    <= pwdata[REL_W-1:0];
        REG_ESCAPE_ABSOLUTE:    cfg.escape_absolute    <= pwdata[DIM_W-1:0];
        REG_LINE_LENGTH:        cfg.line_length        <= pwdata[DIM_W-1:0];
        REG_FIT_LINE_LENGTH:    cfg.fit_line_length    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAPTION_TYPE:       prdata = DATA_W'(cfg.caption_type);
      REG_ESCAPE_MODE:        prdata = DATA_W'(cfg.escape_mode);
      REG_GAP:                prdata = DATA_W'(cfg.gap);
      REG_ESCAPE_IS_RELATIVE: prdata = DATA_W'(cfg.escape_is_relative);
      REG_ESCAPE_RELATIVE:    prdata = DATA_W'(cfg.escape_relative);
      REG_ESCAPE_ABSOLUTE:    prdata = DATA_W'(cfg.escape_absolute);
      REG_LINE_LENGTH:        prdata = DATA_W'(cfg.line_length);
      REG_FIT_LINE_LENGTH:    prdata = DATA_W'(cfg.fit_line_length);
      default:                prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/ctg_rel_offset.sv
module ctg_rel_offset #(
  parameter int COORD_BITS = 30,
  parameter int CW         = 34
) (
  input  logic                         clk,
  input  logic [8:0]                   en,
  input  logic signed [COORD_BITS-1:0] lo,
  input  logic signed [COORD_BITS-1:0] hi,
  input  logic [ctg_pkg::REL_W-1:0]    rel,
  output logic signed [CW-1:0]         off
);
  import ctg_pkg::*;

  localparam int MW = COORD_BITS + 1;   // span magnitude
  localparam int QW = MW - 13;          // span / 10000
  localparam int PW = MW + 1;           // offset magnitude

  logic signed [MW-1:0] d_pos, d_neg;
  logic [MW+RECIP_SPAN_W-1:0] span_prod;
  logic [QW+13:0]       qa_scaled;
  logic                 rem_hit;
  logic [FRAC_W+RECIP_FRAC_W-1:0] frac_prod;
  logic [FRAC_W:0]      qb_scaled;

  // stage registers, one letter per stage
  logic [MW-1:0]     mag_a, mag_b;
  logic [7:0]        neg;
  logic [QW-1:0]     qa_b, qa_c, q1_d;
  logic [REM_W-1:0]  r0_c, r2_g;
  logic [REL_W-1:0]  r1_d;
  logic [PW-1:0]     pq_e, pq_f, pq_g, mag_h;
  logic [FRAC_W-1:0] t_e, t_f;
  logic [QB_W-1:0]   qb_f, qb_g;

  assign d_pos     = MW'(hi) - MW'(lo);
  assign d_neg     = MW'(lo) - MW'(hi);
  assign span_prod = (MW+RECIP_SPAN_W)'(mag_a) * (MW+RECIP_SPAN_W)'(RECIP_SPAN);
  assign qa_scaled = (QW+14)'(qa_b) * (QW+14)'(REL_SCALE);
  assign rem_hit   = r0_c >= REM_W'(REL_SCALE);
  assign frac_prod = (FRAC_W+RECIP_FRAC_W)'(t_e) * (FRAC_W+RECIP_FRAC_W)'(RECIP_FRAC);
  assign qb_scaled = (FRAC_W+1)'(qb_f) * (FRAC_W+1)'(REL_SCALE);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg[0] <= d_pos[MW-1];
      mag_a  <= d_pos[MW-1] ? d_neg : d_pos;
    end
    // first quotient estimate, low by at most one
    if (en[1]) begin
      neg[1] <= neg[0];
      mag_b  <= mag_a;
      qa_b   <= span_prod[RECIP_SPAN_SHIFT +: QW];
    end
    if (en[2]) begin
      neg[2] <= neg[1];
      qa_c   <= qa_b;
      r0_c   <= REM_W'(mag_b - MW'(qa_scaled));
    end
    if (en[3]) begin
      neg[3] <= neg[2];
      q1_d   <= rem_hit ? qa_c + QW'(1) : qa_c;
      r1_d   <= REL_W'(rem_hit ? r0_c - REM_W'(REL_SCALE) : r0_c);
    end
    // whole part times rel, remainder part rounded separately
    if (en[4]) begin
      neg[4] <= neg[3];
      pq_e   <= PW'(q1_d) * PW'(rel);
      t_e    <= FRAC_W'(r1_d) * FRAC_W'(rel) + FRAC_W'(REL_HALF);
    end
    if (en[5]) begin
      neg[5] <= neg[4];
      pq_f   <= pq_e;
      t_f    <= t_e;
      qb_f   <= frac_prod[RECIP_FRAC_SHIFT +: QB_W];
    end
    if (en[6]) begin
      neg[6] <= neg[5];
      pq_g   <= pq_f;
      qb_g   <= qb_f;
      r2_g   <= REM_W'(t_f - FRAC_W'(qb_scaled));
    end
    if (en[7]) begin
      neg[7] <= neg[6];
      mag_h  <= pq_g + PW'(qb_g) + PW'(r2_g >= REM_W'(REL_SCALE));
    end
    // rounding is half away from zero, so the sign goes on last
    if (en[8]) begin
      off    <= neg[7] ? CW'(0) - CW'(mag_h) : CW'(mag_h);
    end
  end

endmodule

>>> hw/rtl/ctg_dist_cmp.sv
module ctg_dist_cmp #(
  parameter int CW = 34
) (
  input  logic                 clk,
  input  logic [4:0]           en,
  input  logic signed [CW-1:0] tx,
  input  logic signed [CW-1:0] ty,
  input  logic signed [CW-1:0] hx,
  input  logic signed [CW-1:0] hy,
  input  logic signed [CW-1:0] vx,
  input  logic signed [CW-1:0] vy,
  output logic                 vless
);
  localparam int DW  = CW - 1;
  localparam int HW  = (DW + 1) / 2;
  localparam int LW  = DW - HW;
  localparam int SQW = 2 * DW;

  logic signed [CW-1:0] pa [4];
  logic signed [CW-1:0] pb [4];
  logic signed [CW-1:0] dp [4];
  logic signed [CW-1:0] dn [4];
  logic [DW-1:0]    mag_next [4];
  logic [SQW-1:0]   sq_next  [4];

  logic [DW-1:0]    mag [4];
  logic [2*HW-1:0]  pp_hh [4];
  logic [HW+LW-1:0] pp_hl [4];
  logic [2*LW-1:0]  pp_ll [4];
  logic [SQW-1:0]   sq [4];
  logic [SQW:0]     dh, dv;

  // the four legs: horizontal candidate dx, dy, vertical candidate dx, dy
  always_comb begin
    pa[0] = hx; pb[0] = tx;
    pa[1] = hy; pb[1] = ty;
    pa[2] = vx; pb[2] = tx;
    pa[3] = vy; pb[3] = ty;
    for (int i = 0; i < 4; i++) begin
      dp[i]       = pa[i] - pb[i];
      dn[i]       = pb[i] - pa[i];
      mag_next[i] = dp[i][CW-1] ? DW'(dn[i]) : DW'(dp[i]);
      sq_next[i]  = (SQW'(pp_hh[i]) << (2 * LW)) + (SQW'(pp_hl[i]) << (LW + 1))
                    + SQW'(pp_ll[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (en[0]) mag[i] <= mag_next[i];
      if (en[1]) begin
        pp_hh[i] <= (2*HW)'(mag[i][DW-1:LW]) * (2*HW)'(mag[i][DW-1:LW]);
        pp_hl[i] <= (HW+LW)'(mag[i][DW-1:LW]) * (HW+LW)'(mag[i][LW-1:0]);
        pp_ll[i] <= (2*LW)'(mag[i][LW-1:0]) * (2*LW)'(mag[i][LW-1:0]);
      end
      if (en[2]) sq[i] <= sq_next[i];
    end
    if (en[3]) begin
      dh <= (SQW+1)'(sq[0]) + (SQW+1)'(sq[1]);
      dv <= (SQW+1)'(sq[2]) + (SQW+1)'(sq[3]);
    end
    if (en[4]) vless <= dv < dh;
  end

endmodule

>>> hw/rtl/ctg_polyline.sv
module ctg_polyline #(
  parameter int CW = 34
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  ctg_pkg::cfg_t        cfg,
  input  logic signed [CW-1:0] tx,
  input  logic signed [CW-1:0] ty,
  input  logic signed [CW-1:0] hx,
  input  logic signed [CW-1:0] hy,
  input  logic signed [CW-1:0] vx,
  input  logic signed [CW-1:0] vy,
  input  logic                 h_right,
  input  logic                 v_bottom,
  input  logic                 vless,
  output ctg_pkg::result_t     res
);
  import ctg_pkg::*;

  logic best, type1, try_v, take_v;
  logic horiz_b, horiz_c, near_b;
  logic signed [CW-1:0] along_b, tip_b, mid, knee;
  logic signed [CW-1:0] p0x, p0y, p1x, p1y;
  logic [1:0] count;

  logic signed [CW-1:0] tx_a, ty_a, ex_a, ey_a;
  logic [1:0]           side_a;
  logic signed [CW-1:0] tx_b, ty_b, ex_b, ey_b, sum_b, knee_len_b;
  logic [1:0]           side_b;

  // escape point choice; the snap caption type swaps the fixed modes and inverts best fit
  always_comb begin
    best   = cfg.escape_mode != ESC_HORIZ && cfg.escape_mode != ESC_VERT;
    type1  = cfg.caption_type == CAP_SNAP;
    try_v  = best || (type1 ? cfg.escape_mode == ESC_HORIZ : cfg.escape_mode == ESC_VERT);
    take_v = try_v && (!best || (type1 ? !vless : vless));
  end

  always_comb begin
    horiz_b = side_a == SIDE_LEFT || side_a == SIDE_RIGHT;
    near_b  = side_a == SIDE_LEFT || side_a == SIDE_TOP;
    along_b = horiz_b ? ex_a : ey_a;
    tip_b   = horiz_b ? tx_a : ty_a;
  end

  always_comb begin
    horiz_c = side_b == SIDE_LEFT || side_b == SIDE_RIGHT;
    // midpoint truncated toward zero
    mid     = (sum_b >>> 1) + CW'(sum_b[CW-1] & sum_b[0]);
    knee    = cfg.fit_line_length ? mid : knee_len_b;
    p0x     = tx_b;
    p0y     = ty_b;
    p1x     = ex_b;
    p1y     = ey_b;
    count   = PTS_TWO;
    if (cfg.caption_type == CAP_SNAP) begin
      if (horiz_c) p0x = ex_b;
      else         p0y = ey_b;
    end else if (cfg.caption_type == CAP_KNEE3 || cfg.caption_type == CAP_KNEE4) begin
      count = PTS_THREE;
      if (horiz_c) p1x = knee;
      else         p1y = knee;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tx_a   <= tx;
      ty_a   <= ty;
      ex_a   <= take_v ? vx : hx;
      ey_a   <= take_v ? vy : hy;
      side_a <= take_v ? (v_bottom ? SIDE_BOTTOM : SIDE_TOP)
                       : (h_right ? SIDE_RIGHT : SIDE_LEFT);
    end
    if (en[1]) begin
      tx_b       <= tx_a;
      ty_b       <= ty_a;
      ex_b       <= ex_a;
      ey_b       <= ey_a;
      side_b     <= side_a;
      sum_b      <= tip_b + along_b;
      knee_len_b <= near_b ? along_b - CW'(cfg.line_length)
                           : along_b + CW'(cfg.line_length);
    end
    if (en[2]) begin
      res.point_count <= count;
      res.p0_x        <= 32'(p0x);
      res.p0_y        <= 32'(p0y);
      res.p1_x        <= 32'(p1x);
      res.p1_y        <= 32'(p1y);
      res.p2_x        <= 32'(ex_b);
      res.p2_y        <= 32'(ey_b);
      res.escape_side <= side_b;
    end
  end

endmodule

>>> hw/rtl/callout_tail_geometry_top.sv
// Callout tail geometry: takes one request per clock (tail point and box), fully pipelined,
// except while a full pipeline waits on a stalled output, and the pipeline keeps filling while
// a finished result waits at the output. It presents the tail polyline after 19 register
// stages: the input register, nine stages that round the relative escape position to
// ten-thousandths of the side with two reciprocal multiply and correct steps, one stage that
// places the escape points, five stages of squared distance compare for best fit and three
// stages of polyline build. Configuration is by an APB-style port, registers at byte address
// 4*i; write them only while no request is in flight.
module callout_tail_geometry_top #(
  parameter int COORD_BITS = 30
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ctg_pkg::ADDR_W-1:0]            paddr,
  input  logic [ctg_pkg::DATA_W-1:0]            pwdata,
  output logic [ctg_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // tail_x, tail_y, box_left, box_top, box_right, box_bottom
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // point_count, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, escape_side
  output logic [ctg_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import ctg_pkg::*;

  localparam int CW    = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 4;
  localparam int DEPTH = 19;

  typedef struct packed {
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] bl;
    logic signed [CW-1:0] bt;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] vy;
    logic                 h_right;
    logic                 v_bottom;
  } geo_t;

  typedef struct packed {
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hy;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic                 h_right;
    logic                 v_bottom;
  } pts_t;

  cfg_t    cfg;
  result_t res;

  logic [DEPTH:1] v, v_prev, en;

  logic [6*COORD_BITS-1:0]       in_q;
  logic signed [COORD_BITS-1:0]  tx1, ty1, bl1, bt1, br1, bb1;
  logic signed [CW-1:0] tx2, ty2, bl2, bt2, lx2, rx2, top2, bot2;
  logic signed [CW-1:0] tx3, ty3, bl3, bt3, lx3, rx3, top3, bot3;
  logic signed [CW-1:0] dl3, dr3, dt3, db3;
  logic signed [CW-1:0] offx, offy;
  geo_t geo_next;
  geo_t geo_q [4:10];
  pts_t pts_q [11:16];
  logic vless;

  ctg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a stage may load when any stage from it to the output is empty, or the output drains
  for (genvar k = 1; k <= DEPTH; k++) begin : g_en
    assign en[k] = m_tready | ~(&v[DEPTH:k]);
  end

  assign v_prev   = {v[DEPTH-1:1], s_tvalid};
  assign s_tready = en[1];
  assign m_tvalid = v[DEPTH];
  assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), res};

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= (v & ~en) | (v_prev & en);
  end

  assign tx1 = in_q[0*COORD_BITS +: COORD_BITS];
  assign ty1 = in_q[1*COORD_BITS +: COORD_BITS];
  assign bl1 = in_q[2*COORD_BITS +: COORD_BITS];
  assign bt1 = in_q[3*COORD_BITS +: COORD_BITS];
  assign br1 = in_q[4*COORD_BITS +: COORD_BITS];
  assign bb1 = in_q[5*COORD_BITS +: COORD_BITS];

  always_comb begin
    geo_next.tx       = tx3;
    geo_next.ty       = ty3;
    geo_next.bl       = bl3;
    geo_next.bt       = bt3;
    geo_next.h_right  = !(dl3 < dr3);
    geo_next.v_bottom = !(dt3 < db3);
    geo_next.hx       = geo_next.h_right ? rx3 : lx3;
    geo_next.vy       = geo_next.v_bottom ? bot3 : top3;
  end

  always_ff @(posedge clk) begin
    if (en[1]) in_q <= s_tdata[6*COORD_BITS-1:0];
    // candidate sides pushed out by the gap
    if (en[2]) begin
      tx2  <= CW'(tx1);
      ty2  <= CW'(ty1);
      bl2  <= CW'(bl1);
      bt2  <= CW'(bt1);
      lx2  <= CW'(bl1) - CW'(cfg.gap);
      rx2  <= CW'(br1) + CW'(cfg.gap);
      top2 <= CW'(bt1) - CW'(cfg.gap);
      bot2 <= CW'(bb1) + CW'(cfg.gap);
    end
    if (en[3]) begin
      tx3  <= tx2;
      ty3  <= ty2;
      bl3  <= bl2;
      bt3  <= bt2;
      lx3  <= lx2;
      rx3  <= rx2;
      top3 <= top2;
      bot3 <= bot2;
      dl3  <= tx2 - lx2;
      dr3  <= rx2 - tx2;
      dt3  <= ty2 - top2;
      db3  <= bot2 - ty2;
    end
    if (en[4]) geo_q[4] <= geo_next;
    for (int k = 5; k <= 10; k++) begin
      if (en[k]) geo_q[k] <= geo_q[k-1];
    end
    // escape position along the side
    if (en[11]) begin
      pts_q[11].tx       <= geo_q[10].tx;
      pts_q[11].ty       <= geo_q[10].ty;
      pts_q[11].hx       <= geo_q[10].hx;
      pts_q[11].vy       <= geo_q[10].vy;
      pts_q[11].h_right  <= geo_q[10].h_right;
      pts_q[11].v_bottom <= geo_q[10].v_bottom;
      pts_q[11].hy       <= geo_q[10].bt +
                            (cfg.escape_is_relative ? offy : CW'(cfg.escape_absolute));
      pts_q[11].vx       <= geo_q[10].bl +
                            (cfg.escape_is_relative ? offx : CW'(cfg.escape_absolute));
    end
    for (int k = 12; k <= 16; k++) begin
      if (en[k]) pts_q[k] <= pts_q[k-1];
    end
  end

  ctg_rel_offset #(.COORD_BITS(COORD_BITS), .CW(CW)) u_off_x (
    .clk (clk),
    .en  (en[10:2]),
    .lo  (bl1),
    .hi  (br1),
    .rel (cfg.escape_relative),
    .off (offx)
  );

  ctg_rel_offset #(.COORD_BITS(COORD_BITS), .CW(CW)) u_off_y (
    .clk (clk),
    .en  (en[10:2]),
    .lo  (bt1),
    .hi  (bb1),
    .rel (cfg.escape_relative),
    .off (offy)
  );

  ctg_dist_cmp #(.CW(CW)) u_dist (
    .clk   (clk),
    .en    (en[16:12]),
    .tx    (pts_q[11].tx),
    .ty    (pts_q[11].ty),
    .hx    (pts_q[11].hx),
    .hy    (pts_q[11].hy),
    .vx    (pts_q[11].vx),
    .vy    (pts_q[11].vy),
    .vless (vless)
  );

  ctg_polyline #(.CW(CW)) u_poly (
    .clk      (clk),
    .en       (en[19:17]),
    .cfg      (cfg),
    .tx       (pts_q[16].tx),
    .ty       (pts_q[16].ty),
    .hx       (pts_q[16].hx),
    .hy       (pts_q[16].hy),
    .vx       (pts_q[16].vx),
    .vy       (pts_q[16].vy),
    .h_right  (pts_q[16].h_right),
    .v_bottom (pts_q[16].v_bottom),
    .vless    (vless),
    .res      (res)
  );

  // an empty input stage always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> s_tready)
    else $error("input stage empty but request refused");

  // two-point results repeat the escape point
  a_two_point_repeat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.point_count == PTS_TWO) |->
      (res.p1_x == res.p2_x && res.p1_y == res.p2_y))
    else $error("two-point polyline with distinct second and third points");

  // snapped tail lies on the escape axis
  a_snap_axis: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && cfg.caption_type == CAP_SNAP &&
     (res.escape_side == SIDE_LEFT || res.escape_side == SIDE_RIGHT)) |->
      res.p0_x == res.p2_x)
    else $error("snapped tail off the escape axis");

  // fixed horizontal escape only ever picks left or right
  a_horiz_side: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && cfg.escape_mode == ESC_HORIZ && cfg.caption_type != CAP_SNAP) |->
      (res.escape_side == SIDE_LEFT || res.escape_side == SIDE_RIGHT))
    else $error("horizontal escape produced a top or bottom side");

endmodule

>>> bench/callout_tail_geometry_top_test.sv
`timescale 1ns / 100ps

module callout_tail_geometry_top_test;
  import ctg_pkg::*;

  localparam int COORD_BITS = 30;
  localparam int IN_W = ((6*COORD_BITS+7)/8)*8;
  localparam longint MAXC = 2**(COORD_BITS-1) - 1;
  localparam longint MINC = -(2**(COORD_BITS-1));
  localparam logic [1:0] ESC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] STALL_PAT = 8'b1011_0010;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] box_bottom;
    logic signed [COORD_BITS-1:0] box_right;
    logic signed [COORD_BITS-1:0] box_top;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] tail_y;
    logic signed [COORD_BITS-1:0] tail_x;
  } shape_t;

  typedef struct {
    cfg_t    cfg;
    shape_t  shape;
    bit      known;
    result_t want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // tail_x, tail_y, box_left, box_top, box_right, box_bottom
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // point_count, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, escape_side
  logic [OUT_TDATA_W-1:0] m_tdata;

  result_t  pending_paths[$];
  dir_row_t dir_rows[$];
  cfg_t     cfg_now;
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  int       shapes_sent = 0;
  int       settings_run = 0;
  int       burst_left = 0;
  int       stall_mode = 0;
  int       side_hits[4] = '{0, 0, 0, 0};

  callout_tail_geometry_top #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // rounding half away from zero to ten-thousandths of the span
  function automatic longint round_tenk(longint span, longint rel);
    longint a;
    a = span * rel;
    a = (a < 0) ? a - REL_HALF : a + REL_HALF;
    return a / REL_SCALE;
  endfunction

  function automatic logic [127:0] sq_dist(longint dx, longint dy);
    logic signed [127:0] a, b;
    a = dx;
    b = dy;
    return a * a + b * b;
  endfunction

  function automatic result_t predict_tail(shape_t s, cfg_t c);
    longint tx, ty, bl, bt, br, bb, g, len, rel, abs_off;
    longint ox, oy, ex, ey, vy, p0x, p0y, p1x, p1y;
    logic [1:0] side, vside;
    logic [127:0] h_d2, v_d2;
    bit best, snap, try_h, try_v, take, horiz;
    result_t r;
    tx = $signed(s.tail_x);
    ty = $signed(s.tail_y);
    bl = $signed(s.box_left);
    bt = $signed(s.box_top);
    br = $signed(s.box_right);
    bb = $signed(s.box_bottom);
    g = c.gap;
    len = c.line_length;
    rel = c.escape_relative;
    abs_off = c.escape_absolute;
    if (c.escape_is_relative) begin
      ox = bl + round_tenk(br - bl, rel);
      oy = bt + round_tenk(bb - bt, rel);
    end else begin
      ox = bl + abs_off;
      oy = bt + abs_off;
    end
    best = (c.escape_mode >= ESC_BEST);
    snap = (c.caption_type == CAP_SNAP);
    // snapped captions swap the meaning of horizontal and vertical
    try_h = best || (snap ? c.escape_mode == ESC_VERT : c.escape_mode == ESC_HORIZ);
    try_v = best || (snap ? c.escape_mode == ESC_HORIZ : c.escape_mode == ESC_VERT);
    side = SIDE_LEFT;
    ex = 0;
    ey = 0;
    if (try_h) begin
      if (tx - (bl - g) < (br + g) - tx) begin
        side = SIDE_LEFT;
        ex = bl - g;
      end else begin
        side = SIDE_RIGHT;
        ex = br + g;
      end
      ey = oy;
    end
    if (try_v) begin
      if (ty - (bt - g) < (bb + g) - ty) begin
        vside = SIDE_TOP;
        vy = bt - g;
      end else begin
        vside = SIDE_BOTTOM;
        vy = bb + g;
      end
      take = !best;
      if (best) begin
        h_d2 = sq_dist(ex - tx, ey - ty);
        v_d2 = sq_dist(ox - tx, vy - ty);
        take = snap ? (v_d2 >= h_d2) : (v_d2 < h_d2);
      end
      if (take) begin
        side = vside;
        ex = ox;
        ey = vy;
      end
    end
    horiz = (side == SIDE_LEFT) || (side == SIDE_RIGHT);
    p0x = tx;
    p0y = ty;
    p1x = ex;
    p1y = ey;
    r.point_count = PTS_TWO;
    if (snap) begin
      if (horiz) p0x = ex;
      else p0y = ey;
    end else if (c.caption_type != CAP_STRAIGHT) begin
      r.point_count = PTS_THREE;
      if (horiz) begin
        if (c.fit_line_length) p1x = (tx + ex) / 2;
        else p1x = (side == SIDE_LEFT) ? ex - len : ex + len;
      end else begin
        if (c.fit_line_length) p1y = (ty + ey) / 2;
        else p1y = (side == SIDE_TOP) ? ey - len : ey + len;
      end
    end
    r.p0_x = p0x[31:0];
    r.p0_y = p0y[31:0];
    r.p1_x = p1x[31:0];
    r.p1_y = p1y[31:0];
    r.p2_x = ex[31:0];
    r.p2_y = ey[31:0];
    r.escape_side = side;
    return r;
  endfunction

  function automatic cfg_t mk_cfg(logic [1:0] cap, logic [1:0] mode, logic [23:0] gap,
                                  bit is_rel, logic [13:0] rel, logic [23:0] abs_off,
                                  logic [23:0] len, bit fit);
    cfg_t c;
    c.caption_type = cap;
    c.escape_mode = mode;
    c.gap = gap;
    c.escape_is_relative = is_rel;
    c.escape_relative = rel;
    c.escape_absolute = abs_off;
    c.line_length = len;
    c.fit_line_length = fit;
    return c;
  endfunction

  function automatic shape_t mk_shape(longint tx, longint ty, longint bl, longint bt,
                                      longint br, longint bb);
    shape_t s;
    s.tail_x = tx[COORD_BITS-1:0];
    s.tail_y = ty[COORD_BITS-1:0];
    s.box_left = bl[COORD_BITS-1:0];
    s.box_top = bt[COORD_BITS-1:0];
    s.box_right = br[COORD_BITS-1:0];
    s.box_bottom = bb[COORD_BITS-1:0];
    return s;
  endfunction

  function automatic result_t mk_res(logic [1:0] cnt, longint p0x, longint p0y, longint p1x,
                                     longint p1y, longint p2x, longint p2y, logic [1:0] side);
    result_t r;
    r.point_count = cnt;
    r.p0_x = p0x[31:0];
    r.p0_y = p0y[31:0];
    r.p1_x = p1x[31:0];
    r.p1_y = p1y[31:0];
    r.p2_x = p2x[31:0];
    r.p2_y = p2y[31:0];
    r.escape_side = side;
    return r;
  endfunction

  // signed value spread over roughly +/- 2**(bits-1)
  function automatic longint spread(int bits);
    return longint'($signed($urandom)) >>> (32 - bits);
  endfunction

  function automatic longint ext_coord();
    case ($urandom_range(0, 4))
      0: return MINC;
      1: return MAXC;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [23:0] pick24();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 1000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic shape_t rand_shape();
    shape_t s;
    longint cx, cy, hw, hh;
    int bits;
    bits = $urandom_range(3, 29);
    cx = spread(bits);
    cy = spread(bits);
    hw = spread(bits - 1);
    hh = spread(bits - 1);
    case ($urandom_range(0, 9))
      0, 1: s = shape_t'((6*COORD_BITS)'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom}));
      2: s = mk_shape(ext_coord(), ext_coord(), ext_coord(), ext_coord(), ext_coord(),
                      ext_coord());
      3: begin
        // tail on a box edge or centre line; on a centre line the nearer-side compare ties
        hw = (hw < 0) ? -hw : hw;
        hh = (hh < 0) ? -hh : hh;
        s = mk_shape($urandom_range(0, 1) ? cx - hw : cx, $urandom_range(0, 1) ? cy + hh : cy,
                     cx - hw, cy - hh, cx + hw, cy + hh);
      end
      default: begin
        // mostly ordered boxes, now and then inverted
        if ($urandom_range(0, 7) != 0) begin
          hw = (hw < 0) ? -hw : hw;
          hh = (hh < 0) ? -hh : hh;
        end
        s = mk_shape(cx + spread(bits + 1), cy + spread(bits + 1), cx - hw, cy - hh,
                     cx + hw, cy + hh);
      end
    endcase
    return s;
  endfunction

  task automatic load_config(cfg_t c);
    logic [31:0] val;
    logic [2:0] idx;
    for (int k = 0; k < 8; k++) begin
      idx = k[2:0];
      case (idx)
        REG_CAPTION_TYPE:       val = 32'(c.caption_type);
        REG_ESCAPE_MODE:        val = 32'(c.escape_mode);
        REG_GAP:                val = 32'(c.gap);
        REG_ESCAPE_IS_RELATIVE: val = 32'(c.escape_is_relative);
        REG_ESCAPE_RELATIVE:    val = 32'(c.escape_relative);
        REG_ESCAPE_ABSOLUTE:    val = 32'(c.escape_absolute);
        REG_LINE_LENGTH:        val = 32'(c.line_length);
        default:                val = 32'(c.fit_line_length);
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_now = c;
    settings_run++;
  endtask

  task automatic push_shape(shape_t s, bit known, result_t want);
    int gap_len;
    s_tdata <= IN_W'(s);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_paths.push_back(known ? want : predict_tail(s, cfg_now));
    shapes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 48);
      gap_len = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
  endtask

  // hold off the sender until every outstanding request has its result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    cycle_cnt++;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (pending_paths.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt++;
      end else begin
        want = pending_paths.pop_front();
        if (got.point_count !== want.point_count) begin
          $error("point_count: expected %0d, got %0d", want.point_count, got.point_count);
          err_cnt++;
        end
        if (got.p0_x !== want.p0_x) begin
          $error("p0_x: expected %0d, got %0d", $signed(want.p0_x), $signed(got.p0_x));
          err_cnt++;
        end
        if (got.p0_y !== want.p0_y) begin
          $error("p0_y: expected %0d, got %0d", $signed(want.p0_y), $signed(got.p0_y));
          err_cnt++;
        end
        if (got.p1_x !== want.p1_x) begin
          $error("p1_x: expected %0d, got %0d", $signed(want.p1_x), $signed(got.p1_x));
          err_cnt++;
        end
        if (got.p1_y !== want.p1_y) begin
          $error("p1_y: expected %0d, got %0d", $signed(want.p1_y), $signed(got.p1_y));
          err_cnt++;
        end
        if (got.p2_x !== want.p2_x) begin
          $error("p2_x: expected %0d, got %0d", $signed(want.p2_x), $signed(got.p2_x));
          err_cnt++;
        end
        if (got.p2_y !== want.p2_y) begin
          $error("p2_y: expected %0d, got %0d", $signed(want.p2_y), $signed(got.p2_y));
          err_cnt++;
        end
        if (got.escape_side !== want.escape_side) begin
          $error("escape_side: expected %0d, got %0d", want.escape_side, got.escape_side);
          err_cnt++;
        end
        side_hits[want.escape_side]++;
      end
    end
    // receiver back-pressure switches at random among always ready, mostly ready, a fixed pattern and mostly stalled
    if (cycle_cnt % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= STALL_PAT[cycle_cnt[2:0]];
      default: m_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("callout_tail_geometry_top_test: errors");
      $finish;
    end
  end

  initial begin
    cfg_t cfg_rst, cfg_snap_h, cfg_snap_v, cfg_snap_best, cfg_line_best;
    cfg_t cfg_fixed_v, cfg_fixed_odd, cfg_rel_over, cfg_far, c;
    int n_items;
    cfg_rst = mk_cfg(CAP_KNEE3, ESC_HORIZ, 0, 1, 5000, 0, 0, 1);
    cfg_snap_h = mk_cfg(CAP_SNAP, ESC_HORIZ, 5, 1, 10000, 0, 0, 1);
    cfg_snap_v = mk_cfg(CAP_SNAP, ESC_VERT, 5, 1, 0, 0, 0, 1);
    cfg_snap_best = mk_cfg(CAP_SNAP, ESC_BEST, 0, 0, 5000, 0, 0, 1);
    cfg_line_best = mk_cfg(CAP_STRAIGHT, ESC_BEST, 0, 0, 5000, 0, 0, 1);
    cfg_fixed_v = mk_cfg(CAP_KNEE4, ESC_VERT, 3, 0, 5000, 7, 11, 0);
    cfg_fixed_odd = mk_cfg(CAP_KNEE3, ESC_UNUSED, 3, 0, 5000, 7, 11, 0);
    cfg_rel_over = mk_cfg(CAP_STRAIGHT, ESC_HORIZ, 0, 1, 14'h3FFF, 0, 0, 1);
    cfg_far = mk_cfg(CAP_KNEE3, ESC_HORIZ, 24'hFFFFFF, 0, 5000, 24'hFFFFFF, 24'hFFFFFF, 0);

    // reset settings: knee at the midpoint, horizontal escape, centred offset
    dir_rows.push_back('{cfg_rst, mk_shape(0, 0, 10, 10, 20, 20), 1'b1,
                         mk_res(PTS_THREE, 0, 0, 5, 15, 10, 15, SIDE_LEFT)});
    dir_rows.push_back('{cfg_rst, mk_shape(100, 0, 10, 10, 20, 20), 1'b1,
                         mk_res(PTS_THREE, 100, 0, 60, 15, 20, 15, SIDE_RIGHT)});
    // equal distance to both sides goes right
    dir_rows.push_back('{cfg_rst, mk_shape(15, 0, 10, 10, 20, 20), 1'b1,
                         mk_res(PTS_THREE, 15, 0, 17, 15, 20, 15, SIDE_RIGHT)});
    dir_rows.push_back('{cfg_rst, mk_shape(MAXC, MAXC, MINC, MINC, MINC, MINC), 1'b1,
                         mk_res(PTS_THREE, MAXC, MAXC, 0, MINC, MINC, MINC, SIDE_RIGHT)});
    dir_rows.push_back('{cfg_rst, mk_shape(MINC, MINC, MAXC, MAXC, MAXC, MAXC), 1'b1,
                         mk_res(PTS_THREE, MINC, MINC, 0, MAXC, MAXC, MAXC, SIDE_LEFT)});
    // inverted box: negative span rounds away from zero
    dir_rows.push_back('{cfg_rst, mk_shape(0, 0, 20, 20, 10, 10), 1'b1,
                         mk_res(PTS_THREE, 0, 0, 10, 15, 20, 15, SIDE_LEFT)});
    dir_rows.push_back('{cfg_snap_h, mk_shape(3, -50, 0, 0, 100, 40), 1'b0, '0});
    dir_rows.push_back('{cfg_snap_h, mk_shape(200, 17, 0, 0, 100, 40), 1'b0, '0});
    dir_rows.push_back('{cfg_snap_v, mk_shape(-30, 7, 0, 0, 100, 40), 1'b0, '0});
    dir_rows.push_back('{cfg_snap_v, mk_shape(130, 90, 0, 0, 100, 40), 1'b0, '0});
    // corner tail: both candidates at the same distance
    dir_rows.push_back('{cfg_snap_best, mk_shape(-10, -10, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_snap_best, mk_shape(50, 10, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_line_best, mk_shape(-10, -10, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_line_best, mk_shape(50, 10, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_line_best, mk_shape(10, 100, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_fixed_v, mk_shape(5, -40, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_fixed_v, mk_shape(5, 90, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_fixed_odd, mk_shape(-40, 5, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_fixed_odd, mk_shape(60, 5, 0, 0, 20, 20), 1'b0, '0});
    dir_rows.push_back('{cfg_rel_over, mk_shape(-5, 0, 0, 0, 1000, 1000), 1'b0, '0});
    dir_rows.push_back('{cfg_rel_over, mk_shape(-5, 0, 1000, 1000, 0, 0), 1'b0, '0});
    dir_rows.push_back('{cfg_far, mk_shape(MAXC, MINC, MINC, MINC, MAXC, MAXC), 1'b0, '0});
    dir_rows.push_back('{cfg_far, mk_shape(MINC, MAXC, MINC, MINC, MAXC, MAXC), 1'b0, '0});

    cfg_now = cfg_rst;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != cfg_now) begin
        settle();
        load_config(dir_rows[i].cfg);
      end
      push_shape(dir_rows[i].shape, dir_rows[i].known, dir_rows[i].want);
    end

    // every caption type against every escape mode, then the two register extremes
    for (int ph = 0; ph < 18; ph++) begin
      if (ph == 16) begin
        c = mk_cfg(CAP_KNEE4, ESC_UNUSED, 24'hFFFFFF, 1, 14'h3FFF, 24'hFFFFFF, 24'hFFFFFF, 0);
      end else if (ph == 17) begin
        c = mk_cfg(CAP_SNAP, ESC_HORIZ, 0, 0, 0, 0, 0, 0);
      end else begin
        c.caption_type = ph[1:0];
        c.escape_mode = ph[3:2];
        c.gap = pick24();
        c.escape_is_relative = $urandom_range(0, 2) != 0;
        c.escape_relative = ($urandom_range(0, 4) == 0) ? 14'($urandom_range(0, 16383))
                                                        : 14'($urandom_range(0, 10000));
        c.escape_absolute = pick24();
        c.line_length = pick24();
        c.fit_line_length = 1'($urandom_range(0, 1));
      end
      settle();
      load_config(c);
      n_items = (ph >= 16) ? 40 : 78;
      for (int i = 0; i < n_items; i++) push_shape(rand_shape(), 1'b0, '0);
    end

    settle();
    repeat (40) @(posedge clk);
    $display("%0d shapes sent under %0d register settings", shapes_sent, settings_run + 1);
    $display("escape sides seen: left %0d, right %0d, top %0d, bottom %0d",
             side_hits[0], side_hits[1], side_hits[2], side_hits[3]);
    if (err_cnt == 0) begin
      $display("callout_tail_geometry_top_test: clean");
    end else begin
      $display("callout_tail_geometry_top_test: errors");
    end
    $finish;
  end

endmodule
